// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/ffra_pkg.sv -----
// Package: constants, codes and control/status types of the range allocator.
package ffra_pkg;
   localparam int ADDR_BITS       = 16;
   localparam int MAX_REGIONS_DEF = 16;
   localparam int STATUS_BITS     = 3;
   localparam logic [ADDR_BITS-1:0] HEAP_RESET = 16'd1024;

   localparam logic [STATUS_BITS-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_NOFIT    = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_NOTALLOC = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_ZERO     = 3'd4;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic REG_HEAP_UNITS = 1'b0;

   typedef struct packed {
      logic                   latch;
      logic                   clr_idx;
      logic                   step_idx;
      logic                   capture_k;
      logic                   commit_alloc;
      logic                   commit_free;
      logic                   finish;
      logic [STATUS_BITS-1:0] code;
   } ctl_type;

   typedef struct packed {
      logic amt_zero;
      logic free_end;
      logic used_end;
      logic a_hit;
      logic u_hit;
      logic f_stop;
      logic used_full;
      logic need_slot;
   } stat_type;
endpackage

// ----- rtl/core/ffra_ctrl.sv -----
// Controller: sequences the table scans and the commit of one request.
`include "assert_macros.svh"
module ffra_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              req_command,
   input  ffra_pkg::stat_type stat,
   output ffra_pkg::ctl_type  ctl,
   output logic              busy,
   output logic              rsp_valid
);
   import ffra_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ASCAN = 3'd1;
   localparam logic [2:0] S_USCAN = 3'd2;
   localparam logic [2:0] S_FSCAN = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      ctl.code = ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.latch   = 1'b1;
               ctl.clr_idx = 1'b1;
               state_in    = (req_command == CMD_FREE) ? S_USCAN : S_ASCAN;
            end
         end
         S_ASCAN: begin
            if (stat.amt_zero) begin
               ctl.finish = 1'b1;
               ctl.code   = ST_ZERO;
               state_in   = S_DONE;
            end else if (stat.free_end) begin
               ctl.finish = 1'b1;
               ctl.code   = ST_NOFIT;
               state_in   = S_DONE;
            end else if (stat.a_hit) begin
               if (stat.used_full) begin
                  ctl.finish = 1'b1;
                  ctl.code   = ST_FULL;
               end else begin
                  ctl.commit_alloc = 1'b1;
               end
               state_in = S_DONE;
            end else begin
               ctl.step_idx = 1'b1;
            end
         end
         S_USCAN: begin
            if (stat.used_end) begin
               ctl.finish = 1'b1;
               ctl.code   = ST_NOTALLOC;
               state_in   = S_DONE;
            end else if (stat.u_hit) begin
               ctl.capture_k = 1'b1;
               ctl.clr_idx   = 1'b1;
               state_in      = S_FSCAN;
            end else begin
               ctl.step_idx = 1'b1;
            end
         end
         S_FSCAN: begin
            if (stat.f_stop) begin
               if (stat.need_slot) begin
                  ctl.finish = 1'b1;
                  ctl.code   = ST_FULL;
               end else begin
                  ctl.commit_free = 1'b1;
               end
               state_in = S_DONE;
            end else begin
               ctl.step_idx = 1'b1;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

   `ASSERT_NEXT(a_word_one_cycle, clock, reset, rsp_valid, !rsp_valid)
   `ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `ASSERT_NEXT(a_word_then_idle, clock, reset, rsp_valid, !busy)
endmodule

// ----- rtl/core/ffra_dpath.sv -----
// Datapath: free/used region tables, scan index, result registers.
`include "assert_macros.svh"
module ffra_dpath #(
   parameter int MAX_REGIONS = ffra_pkg::MAX_REGIONS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ffra_pkg::ctl_type                   ctl,
   input  logic                                init,
   input  logic [ffra_pkg::ADDR_BITS-1:0]      init_units,
   input  logic [ffra_pkg::ADDR_BITS-1:0]      req_amount,
   input  logic [ffra_pkg::ADDR_BITS-1:0]      req_region_start,
   output ffra_pkg::stat_type                  stat,
   output logic [ffra_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic [ffra_pkg::ADDR_BITS-1:0]      rsp_granted_start,
   output logic [ffra_pkg::ADDR_BITS-1:0]      rsp_freed_units
);
   import ffra_pkg::*;

   localparam int IDX_W = $clog2(MAX_REGIONS);
   localparam int CNT_W = $clog2(MAX_REGIONS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REGIONS);

   typedef logic [ADDR_BITS-1:0] addr_type;

   addr_type ff_ff [MAX_REGIONS];
   addr_type fl_ff [MAX_REGIONS];
   addr_type uf_ff [MAX_REGIONS];
   addr_type ul_ff [MAX_REGIONS];
   addr_type ff_in [MAX_REGIONS];
   addr_type fl_in [MAX_REGIONS];
   addr_type uf_in [MAX_REGIONS];
   addr_type ul_in [MAX_REGIONS];
   addr_type ff_dn [MAX_REGIONS];
   addr_type fl_dn [MAX_REGIONS];
   addr_type ff_up [MAX_REGIONS];
   addr_type fl_up [MAX_REGIONS];
   addr_type uf_dn [MAX_REGIONS];
   addr_type ul_dn [MAX_REGIONS];

   logic [CNT_W-1:0] free_count_ff, free_count_in;
   logic [CNT_W-1:0] used_count_ff, used_count_in;
   logic [CNT_W-1:0] idx_ff, k_ff;
   addr_type amount_ff, start_ff, last_ff, prev_last_ff;
   logic [STATUS_BITS-1:0] status_ff;
   addr_type granted_ff, freed_ff;

   addr_type rf_first, rf_last, ru_first, ru_last;
   logic [ADDR_BITS:0] size;
   logic prev_touch, next_touch, free_full;

   // neighbor views of the tables for the shift operations
   for (genvar gj = 0; gj < MAX_REGIONS; gj++) begin : g_nb
      if (gj < MAX_REGIONS - 1) begin : g_dn
         assign ff_dn[gj] = ff_ff[gj+1];
         assign fl_dn[gj] = fl_ff[gj+1];
         assign uf_dn[gj] = uf_ff[gj+1];
         assign ul_dn[gj] = ul_ff[gj+1];
      end else begin : g_dn_end
         assign ff_dn[gj] = '0;
         assign fl_dn[gj] = '0;
         assign uf_dn[gj] = '0;
         assign ul_dn[gj] = '0;
      end
      if (gj > 0) begin : g_up
         assign ff_up[gj] = ff_ff[gj-1];
         assign fl_up[gj] = fl_ff[gj-1];
      end else begin : g_up_end
         assign ff_up[gj] = '0;
         assign fl_up[gj] = '0;
      end
   end

   assign rf_first = ff_ff[idx_ff[IDX_W-1:0]];
   assign rf_last  = fl_ff[idx_ff[IDX_W-1:0]];
   assign ru_first = uf_ff[idx_ff[IDX_W-1:0]];
   assign ru_last  = ul_ff[idx_ff[IDX_W-1:0]];

   assign size      = {1'b0, rf_last} - {1'b0, rf_first} + (ADDR_BITS+1)'(1);
   assign free_full = (free_count_ff == CNT_MAX);

   assign prev_touch = (idx_ff != '0) &&
                       ({1'b0, prev_last_ff} + (ADDR_BITS+1)'(1) == {1'b0, start_ff});
   assign next_touch = (idx_ff < free_count_ff) &&
                       ({1'b0, last_ff} + (ADDR_BITS+1)'(1) == {1'b0, rf_first});

   always_comb begin
      stat.amt_zero  = (amount_ff == '0);
      stat.free_end  = (idx_ff >= free_count_ff);
      stat.used_end  = (idx_ff >= used_count_ff);
      stat.a_hit     = (size >= {1'b0, amount_ff});
      stat.u_hit     = (ru_first == start_ff);
      stat.f_stop    = stat.free_end || (rf_first > start_ff);
      stat.used_full = (used_count_ff == CNT_MAX);
      stat.need_slot = !prev_touch && !next_touch && free_full;
   end

   // table updates: heap init, allocate commit or free commit
   always_comb begin
      ff_in         = ff_ff;
      fl_in         = fl_ff;
      uf_in         = uf_ff;
      ul_in         = ul_ff;
      free_count_in = free_count_ff;
      used_count_in = used_count_ff;
      if (init) begin
         ff_in[0]      = addr_type'(1);
         fl_in[0]      = init_units;
         free_count_in = (init_units != '0) ? CNT_W'(1) : '0;
         used_count_in = '0;
      end else if (ctl.commit_alloc) begin
         uf_in[used_count_ff[IDX_W-1:0]] = rf_first;
         ul_in[used_count_ff[IDX_W-1:0]] = rf_first + amount_ff - addr_type'(1);
         used_count_in = used_count_ff + CNT_W'(1);
         if (size == {1'b0, amount_ff}) begin
            for (int j = 0; j < MAX_REGIONS; j++) begin
               if (CNT_W'(j) >= idx_ff && CNT_W'(j) + CNT_W'(1) < free_count_ff) begin
                  ff_in[j] = ff_dn[j];
                  fl_in[j] = fl_dn[j];
               end
            end
            free_count_in = free_count_ff - CNT_W'(1);
         end else begin
            ff_in[idx_ff[IDX_W-1:0]] = rf_first + amount_ff;
         end
      end else if (ctl.commit_free) begin
         for (int j = 0; j < MAX_REGIONS; j++) begin
            if (CNT_W'(j) >= k_ff && CNT_W'(j) + CNT_W'(1) < used_count_ff) begin
               uf_in[j] = uf_dn[j];
               ul_in[j] = ul_dn[j];
            end
         end
         used_count_in = used_count_ff - CNT_W'(1);
         if (prev_touch && next_touch) begin
            for (int j = 0; j < MAX_REGIONS; j++) begin
               if (CNT_W'(j) + CNT_W'(1) == idx_ff) begin
                  fl_in[j] = rf_last;
               end else if (CNT_W'(j) >= idx_ff &&
                            CNT_W'(j) + CNT_W'(1) < free_count_ff) begin
                  ff_in[j] = ff_dn[j];
                  fl_in[j] = fl_dn[j];
               end
            end
            free_count_in = free_count_ff - CNT_W'(1);
         end else if (prev_touch) begin
            fl_in[idx_ff[IDX_W-1:0] - IDX_W'(1)] = last_ff;
         end else if (next_touch) begin
            ff_in[idx_ff[IDX_W-1:0]] = start_ff;
         end else begin
            for (int j = 0; j < MAX_REGIONS; j++) begin
               if (CNT_W'(j) == idx_ff) begin
                  ff_in[j] = start_ff;
                  fl_in[j] = last_ff;
               end else if (CNT_W'(j) > idx_ff && CNT_W'(j) <= free_count_ff) begin
                  ff_in[j] = ff_up[j];
                  fl_in[j] = fl_up[j];
               end
            end
            free_count_in = free_count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_count_ff <= CNT_W'(1);
         used_count_ff <= '0;
      end else begin
         free_count_ff <= free_count_in;
         used_count_ff <= used_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ff_ff[0] <= addr_type'(1);
         fl_ff[0] <= HEAP_RESET;
      end else begin
         ff_ff <= ff_in;
         fl_ff <= fl_in;
      end
   end

   always_ff @(posedge clock) begin
      uf_ff <= uf_in;
      ul_ff <= ul_in;
   end

   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         amount_ff <= req_amount;
         start_ff  <= req_region_start;
      end
      if (ctl.clr_idx) begin
         idx_ff <= '0;
      end else if (ctl.step_idx) begin
         idx_ff <= idx_ff + CNT_W'(1);
      end
      if (ctl.step_idx) begin
         prev_last_ff <= rf_last;
      end
      if (ctl.capture_k) begin
         k_ff    <= idx_ff;
         last_ff <= ru_last;
      end
      if (ctl.finish) begin
         status_ff  <= ctl.code;
         granted_ff <= '0;
         freed_ff   <= '0;
      end else if (ctl.commit_alloc) begin
         status_ff  <= ST_OK;
         granted_ff <= rf_first;
         freed_ff   <= '0;
      end else if (ctl.commit_free) begin
         status_ff  <= ST_OK;
         granted_ff <= '0;
         freed_ff   <= last_ff - start_ff + addr_type'(1);
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_granted_start = granted_ff;
   assign rsp_freed_units   = freed_ff;

   `ASSERT_ALWAYS(a_free_bound, clock, reset, free_count_ff <= CNT_MAX)
   `ASSERT_ALWAYS(a_used_bound, clock, reset, used_count_ff <= CNT_MAX)
   `ASSERT_NEXT(a_alloc_grows, clock, reset, ctl.commit_alloc && !init, used_count_ff == $past(used_count_ff) + CNT_W'(1))
endmodule

// ----- rtl/core/first_fit_range_allocator.sv -----
// Top level: first-fit range allocator with coalescing free table.
//
//  channel   handshake           ports
//  request   start && !busy      req_command, req_amount, req_region_start
//  result    rsp_valid strobe    rsp_status, rsp_granted_start, rsp_freed_units
//  csr       psel&penable&pwrite paddr, pwdata, prdata, pready
//
// An allocate scans the free table for the first fit, then commits it.
// A free scans the used table, then the free table, then commits.
// rsp_valid marks the result word on the rsp_ ports for one cycle; the block is idle the cycle after.
// Reset or a heap_units write leaves one free region [1, heap_units] (none if heap_units is 0) and no used regions.
// The receiver cannot stall; the next request is taken once busy drops.
module first_fit_range_allocator #(
   parameter int MAX_REGIONS = ffra_pkg::MAX_REGIONS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_command,
   input  logic [ffra_pkg::ADDR_BITS-1:0]    req_amount,
   input  logic [ffra_pkg::ADDR_BITS-1:0]    req_region_start,
   output logic                              rsp_valid,
   output logic [ffra_pkg::STATUS_BITS-1:0]  rsp_status,
   output logic [ffra_pkg::ADDR_BITS-1:0]    rsp_granted_start,
   output logic [ffra_pkg::ADDR_BITS-1:0]    rsp_freed_units,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [2:0]                        paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import ffra_pkg::*;

   logic [ADDR_BITS-1:0] heap_units_ff;
   logic                 heap_wr;
   ctl_type              ctl;
   stat_type             stat;

   assign pready  = 1'b1;
   assign heap_wr = psel && penable && pwrite && (paddr[2] == REG_HEAP_UNITS);
   assign prdata  = (paddr[2] == REG_HEAP_UNITS) ? 32'(heap_units_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_units_ff <= HEAP_RESET;
      end else if (heap_wr) begin
         heap_units_ff <= pwdata[ADDR_BITS-1:0];
      end
   end

   ffra_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .stat        (stat),
      .ctl         (ctl),
      .busy        (busy),
      .rsp_valid   (rsp_valid)
   );

   ffra_dpath #(
      .MAX_REGIONS (MAX_REGIONS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .init              (heap_wr),
      .init_units        (pwdata[ADDR_BITS-1:0]),
      .req_amount        (req_amount),
      .req_region_start  (req_region_start),
      .stat              (stat),
      .rsp_status        (rsp_status),
      .rsp_granted_start (rsp_granted_start),
      .rsp_freed_units   (rsp_freed_units)
   );
endmodule
